[sv/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the module's clk, disabled while arst_n is low.
`define JET_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define JET_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[sv/jet_pkg.sv]
package jet_pkg;

	localparam int FRAC_BITS    = 26;
	localparam int IMAGE_WIDTH  = 1024;
	localparam int IMAGE_HEIGHT = 1024;

	localparam int PIX_W   = 10;
	localparam int Q_W     = 32;
	localparam int STEP_W  = 31;
	localparam int ITER_W  = 16;
	localparam int CSTEP_W = 24;
	localparam int COLOR_W = 32;
	localparam int WIDE_W  = 64;
	// pixel minus half the image, signed; covers image sizes up to 8192
	localparam int OFF_W   = 13;
	localparam int PROD_W  = OFF_W + Q_W;

	// 4.0 at the precision of a full square
	localparam logic [WIDE_W-1:0] ESC_LIMIT = WIDE_W'(4) << (2 * FRAC_BITS);

	localparam logic signed [WIDE_W-1:0] Q_MAX = (WIDE_W'(1) <<< (Q_W - 1)) - WIDE_W'(1);
	localparam logic signed [WIDE_W-1:0] Q_MIN = -(WIDE_W'(1) <<< (Q_W - 1));

	// APB register map
	localparam int APB_W     = 32;
	localparam int ADDR_W    = 5;
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_C_REAL    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_C_IMAG    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_CENTER_X  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_CENTER_Y  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_PIX_STEP  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_MAX_ITER  = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_COLOR_STP = 3'd6;

	localparam logic [STEP_W-1:0]  RST_PIX_STEP  = 31'd262144;
	localparam logic [ITER_W-1:0]  RST_MAX_ITER  = 16'd100;
	localparam logic [CSTEP_W-1:0] RST_COLOR_STP = 24'd1;

	typedef struct packed {
		logic signed [Q_W-1:0] c_real;
		logic signed [Q_W-1:0] c_imag;
		logic signed [Q_W-1:0] center_x;
		logic signed [Q_W-1:0] center_y;
		logic [STEP_W-1:0]     pixel_step;
		logic [ITER_W-1:0]     max_iterations;
		logic [CSTEP_W-1:0]    color_step;
	} cfg_t;

	typedef struct packed {
		logic start;
		logic init;
		logic mul;
		logic upd;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic stop;
		logic out_free;
	} stat_t;

	function automatic logic signed [Q_W-1:0] sat_q(input logic signed [WIDE_W-1:0] v);
		logic signed [Q_W-1:0] r;
		if (v > Q_MAX) begin
			r = Q_W'(Q_MAX);
		end else if (v < Q_MIN) begin
			r = Q_W'(Q_MIN);
		end else begin
			r = v[Q_W-1:0];
		end
		return r;
	endfunction

endpackage

[sv/jet_pix_if.sv]
interface jet_pix_if;
	logic                      valid;
	logic                      ready;
	logic [jet_pkg::PIX_W-1:0] pixel_x;
	logic [jet_pkg::PIX_W-1:0] pixel_y;

	modport source(output valid, pixel_x, pixel_y, input ready);
	modport sink(input valid, pixel_x, pixel_y, output ready);
endinterface

[sv/jet_res_if.sv]
interface jet_res_if;
	logic                        valid;
	logic                        ready;
	logic [jet_pkg::COLOR_W-1:0] color;
	logic [jet_pkg::ITER_W-1:0]  iterations_done;
	logic                        escaped;

	modport source(output valid, color, iterations_done, escaped, input ready);
	modport sink(input valid, color, iterations_done, escaped, output ready);
endinterface

[sv/jet_regs.sv]
module jet_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [jet_pkg::ADDR_W-1:0]   paddr,
	input  logic [jet_pkg::APB_W-1:0]    pwdata,
	output logic [jet_pkg::APB_W-1:0]    prdata,
	output logic                         pready,
	output jet_pkg::cfg_t                cfg
);

	jet_pkg::cfg_t                   cfg_q;
	logic [jet_pkg::REG_IDX_W-1:0]   idx;
	logic                            wr_en;

	assign idx    = paddr[jet_pkg::ADDR_W-1:2];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.c_real         <= '0;
			cfg_q.c_imag         <= '0;
			cfg_q.center_x       <= '0;
			cfg_q.center_y       <= '0;
			cfg_q.pixel_step     <= jet_pkg::RST_PIX_STEP;
			cfg_q.max_iterations <= jet_pkg::RST_MAX_ITER;
			cfg_q.color_step     <= jet_pkg::RST_COLOR_STP;
		end else if (wr_en) begin
			unique case (idx)
				jet_pkg::REG_C_REAL:    cfg_q.c_real         <= pwdata;
				jet_pkg::REG_C_IMAG:    cfg_q.c_imag         <= pwdata;
				jet_pkg::REG_CENTER_X:  cfg_q.center_x       <= pwdata;
				jet_pkg::REG_CENTER_Y:  cfg_q.center_y       <= pwdata;
				jet_pkg::REG_PIX_STEP:  cfg_q.pixel_step     <= pwdata[jet_pkg::STEP_W-1:0];
				jet_pkg::REG_MAX_ITER:  cfg_q.max_iterations <= pwdata[jet_pkg::ITER_W-1:0];
				jet_pkg::REG_COLOR_STP: cfg_q.color_step     <= pwdata[jet_pkg::CSTEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			jet_pkg::REG_C_REAL:    prdata = cfg_q.c_real;
			jet_pkg::REG_C_IMAG:    prdata = cfg_q.c_imag;
			jet_pkg::REG_CENTER_X:  prdata = cfg_q.center_x;
			jet_pkg::REG_CENTER_Y:  prdata = cfg_q.center_y;
			jet_pkg::REG_PIX_STEP:  prdata = jet_pkg::APB_W'(cfg_q.pixel_step);
			jet_pkg::REG_MAX_ITER:  prdata = jet_pkg::APB_W'(cfg_q.max_iterations);
			jet_pkg::REG_COLOR_STP: prdata = jet_pkg::APB_W'(cfg_q.color_step);
			default:                prdata = '0;
		endcase
	end

endmodule

[sv/jet_ctrl.sv]
`include "assert_macros.svh"

module jet_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  jet_pkg::stat_t stat,
	output jet_pkg::cmd_t  cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_INIT = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_UPD  = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready  = (state_q == S_IDLE);
	assign cmd.start = in_valid && in_ready;
	assign cmd.init  = (state_q == S_INIT);
	assign cmd.mul   = (state_q == S_MUL);
	assign cmd.upd   = (state_q == S_UPD) && !stat.stop;
	assign cmd.fin   = (state_q == S_FIN) && stat.out_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.start) state_d = S_INIT;
			end
			S_INIT: state_d = S_MUL;
			S_MUL:  state_d = S_UPD;
			S_UPD: begin
				state_d = stat.stop ? S_FIN : S_MUL;
			end
			S_FIN: begin
				// hold until the output register is free
				if (stat.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`JET_ASSERT(a_accept_starts, in_valid && in_ready |=> state_q == S_INIT, "accept did not start setup")
	`JET_ASSERT(a_loop_back, state_q == S_UPD && !stat.stop |=> state_q == S_MUL, "iteration did not loop")
	`JET_ASSERT(a_fin_entry, state_q == S_FIN |-> ($past(state_q) == S_UPD || $past(state_q) == S_FIN), "finish not after update")

endmodule

[sv/jet_dp.sv]
`include "assert_macros.svh"

module jet_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  jet_pkg::cfg_t                cfg,
	input  jet_pkg::cmd_t                cmd,
	output jet_pkg::stat_t               stat,
	input  logic [jet_pkg::PIX_W-1:0]    pixel_x,
	input  logic [jet_pkg::PIX_W-1:0]    pixel_y,
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic [jet_pkg::COLOR_W-1:0]  color,
	output logic [jet_pkg::ITER_W-1:0]   iterations_done,
	output logic                         escaped
);

	logic signed [jet_pkg::OFF_W-1:0]   off_x;
	logic signed [jet_pkg::OFF_W-1:0]   off_y;
	logic signed [jet_pkg::PROD_W-1:0]  start_x_q;
	logic signed [jet_pkg::PROD_W-1:0]  start_y_q;
	logic signed [jet_pkg::Q_W-1:0]     zx_q;
	logic signed [jet_pkg::Q_W-1:0]     zy_q;
	logic signed [jet_pkg::WIDE_W-1:0]  xx_q;
	logic signed [jet_pkg::WIDE_W-1:0]  yy_q;
	logic signed [jet_pkg::WIDE_W-1:0]  xy_q;
	logic [jet_pkg::ITER_W-1:0]         count_q;
	logic [jet_pkg::WIDE_W-1:0]         mag;
	logic signed [jet_pkg::WIDE_W-1:0]  diff;
	logic signed [jet_pkg::WIDE_W-1:0]  re_sum;
	logic signed [jet_pkg::WIDE_W-1:0]  im_sum;
	logic                               at_max;
	logic                               res_valid_q;
	logic [jet_pkg::COLOR_W-1:0]        color_q;
	logic [jet_pkg::ITER_W-1:0]         iters_q;
	logic                               escaped_q;

	assign off_x = $signed({{(jet_pkg::OFF_W - jet_pkg::PIX_W){1'b0}}, pixel_x})
		- $signed(jet_pkg::OFF_W'(jet_pkg::IMAGE_WIDTH / 2));
	assign off_y = $signed({{(jet_pkg::OFF_W - jet_pkg::PIX_W){1'b0}}, pixel_y})
		- $signed(jet_pkg::OFF_W'(jet_pkg::IMAGE_HEIGHT / 2));

	// squares are never negative, so their sum fits unsigned
	assign mag    = $unsigned(xx_q) + $unsigned(yy_q);
	assign at_max = (count_q >= cfg.max_iterations);
	assign diff   = xx_q - yy_q;
	assign re_sum = (diff >>> jet_pkg::FRAC_BITS) + jet_pkg::WIDE_W'(cfg.c_real);
	// doubling folds into the shift
	assign im_sum = (xy_q >>> (jet_pkg::FRAC_BITS - 1)) + jet_pkg::WIDE_W'(cfg.c_imag);

	assign stat.stop     = (mag > jet_pkg::ESC_LIMIT) || at_max;
	assign stat.out_free = !res_valid_q || res_ready;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			start_x_q <= off_x * $signed({1'b0, cfg.pixel_step});
			start_y_q <= off_y * $signed({1'b0, cfg.pixel_step});
		end
		if (cmd.init) begin
			zx_q    <= jet_pkg::sat_q(jet_pkg::WIDE_W'(cfg.center_x)
				+ jet_pkg::WIDE_W'(start_x_q));
			zy_q    <= jet_pkg::sat_q(jet_pkg::WIDE_W'(cfg.center_y)
				+ jet_pkg::WIDE_W'(start_y_q));
			count_q <= '0;
		end else if (cmd.upd) begin
			zx_q    <= jet_pkg::sat_q(re_sum);
			zy_q    <= jet_pkg::sat_q(im_sum);
			count_q <= count_q + 1'b1;
		end
		if (cmd.mul) begin
			xx_q <= zx_q * zx_q;
			yy_q <= zy_q * zy_q;
			xy_q <= zx_q * zy_q;
		end
		if (cmd.fin) begin
			color_q   <= at_max ? '0
				: jet_pkg::COLOR_W'(count_q) * jet_pkg::COLOR_W'(cfg.color_step);
			iters_q   <= count_q;
			escaped_q <= !at_max;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_valid       = res_valid_q;
	assign color           = color_q;
	assign iterations_done = iters_q;
	assign escaped         = escaped_q;

	`JET_ASSERT(a_bounded_black, res_valid_q && !escaped_q |-> color_q == '0, "bounded pixel has color")

endmodule

[sv/julia_escape_time_pixel_top.sv]
// Julia set escape-time pixel engine. Each pixel beat (pixel_x, pixel_y) is mapped to
// z = center + (pixel - image middle) * pixel_step in signed Q6.26, then z = z^2 + c is
// iterated until |z|^2 exceeds 4 or max_iterations is reached, and one result beat gives
// color, iterations_done and escaped. One pixel is in flight at a time. The iteration loop
// alternates a multiply state, which forms the three 32x32 products, with an update state,
// which applies the update and the escape test. The next pixel is accepted while a finished
// result still waits in the output register. Configuration must be written over APB only
// while the engine is idle; the block itself does not enforce this.
module julia_escape_time_pixel_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [jet_pkg::ADDR_W-1:0]  paddr,
	input  logic [jet_pkg::APB_W-1:0]   pwdata,
	output logic [jet_pkg::APB_W-1:0]   prdata,
	output logic                        pready,
	jet_pix_if.sink                     pix,
	jet_res_if.source                   res
);

	jet_pkg::cfg_t  cfg;
	jet_pkg::cmd_t  cmd;
	jet_pkg::stat_t stat;

	jet_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	jet_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pix.valid),
		.in_ready (pix.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	jet_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.cmd             (cmd),
		.stat            (stat),
		.pixel_x         (pix.pixel_x),
		.pixel_y         (pix.pixel_y),
		.res_valid       (res.valid),
		.res_ready       (res.ready),
		.color           (res.color),
		.iterations_done (res.iterations_done),
		.escaped         (res.escaped)
	);

endmodule
